// ----- rtl/level_set_curvature_stencil_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property wrappers for the curvature stencil unit.
// ----------------------------------------------------------------------------
`ifndef LEVEL_SET_CURVATURE_STENCIL_UNIT_MACROS_SVH
`define LEVEL_SET_CURVATURE_STENCIL_UNIT_MACROS_SVH

// same-cycle implication
`define LSCS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lscs assertion failed");

// next-cycle implication
`define LSCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lscs assertion failed");

`endif

// ----- rtl/lscs_pkg.sv -----
// ----------------------------------------------------------------------------
// lscs_pkg
// Types and constants of the curvature stencil unit.
// ----------------------------------------------------------------------------
package lscs_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int MAX_WIDTH = 1024;
	localparam int MAX_HGT   = 4096;
	localparam int COL_W     = 10;
	localparam int ROW_W     = 12;
	localparam int WID_W     = 11;
	localparam int HGT_W     = 13;

	localparam int MAG_W     = 18;
	localparam int SQ_W      = 33;
	localparam int G_W       = 34;
	localparam int N_W       = 54;
	localparam int NMAG_W    = 53;
	localparam int PROD_W    = 106;
	localparam int G2_W      = 68;
	localparam int G3_W      = 102;
	localparam int FRAC_W    = 32;
	localparam int DVD_W     = PROD_W + FRAC_W;
	localparam int QUO_W     = 64;
	localparam int ROOT_W    = 32;

	localparam int CNT_W       = 8;
	localparam int MUL_CYCLES  = NMAG_W;
	localparam int DIV_CYCLES  = DVD_W;
	localparam int SQRT_CYCLES = ROOT_W;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef enum logic [3:0] {
		OP_DY2, OP_DX2, OP_T1, OP_T3, OP_P, OP_T2, OP_N2, OP_G2, OP_G3
	} mul_op_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] tl;
		logic signed [SAMPLE_W-1:0] t;
		logic signed [SAMPLE_W-1:0] tr;
		logic signed [SAMPLE_W-1:0] l;
		logic signed [SAMPLE_W-1:0] c;
		logic signed [SAMPLE_W-1:0] r;
		logic signed [SAMPLE_W-1:0] bl;
		logic signed [SAMPLE_W-1:0] b;
		logic signed [SAMPLE_W-1:0] br;
	} stencil_t;

	typedef struct packed {
		logic    capture;
		logic    mul_load;
		logic    mul_step;
		logic    mul_store;
		mul_op_t op;
		logic    div_load;
		logic    div_step;
		logic    sqrt_load;
		logic    sqrt_step;
		logic    emit;
	} cmd_t;

	typedef struct packed {
		logic interior;
		logic g_zero;
		logic out_free;
	} stat_t;

endpackage

// ----- rtl/lscs_window.sv -----
// ----------------------------------------------------------------------------
// lscs_window
// Raster counters, two line buffers and the 3x3 sample window.
// ----------------------------------------------------------------------------
module lscs_window (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  accept,
	input  logic signed [lscs_pkg::SAMPLE_W-1:0]  sample,
	input  logic                                  frame_start,
	input  logic [lscs_pkg::WID_W-1:0]            width_eff,
	input  logic [lscs_pkg::HGT_W-1:0]            height_eff,
	input  logic                                  capture,
	output lscs_pkg::stencil_t                    stencil,
	output logic                                  interior,
	output logic                                  frame_end
);

	logic [lscs_pkg::SAMPLE_W-1:0] mem_up  [lscs_pkg::MAX_WIDTH];
	logic [lscs_pkg::SAMPLE_W-1:0] mem_mid [lscs_pkg::MAX_WIDTH];

	logic [lscs_pkg::COL_W-1:0] col_q;
	logic [lscs_pkg::ROW_W-1:0] row_q;
	logic [lscs_pkg::COL_W-1:0] x_q;
	logic signed [lscs_pkg::SAMPLE_W-1:0] s_q;
	logic signed [lscs_pkg::SAMPLE_W-1:0] up_q, mid_q;
	logic signed [lscs_pkg::SAMPLE_W-1:0] win_q [6];
	logic interior_q, frame_end_q;

	logic [lscs_pkg::COL_W-1:0] col0, x;
	logic [lscs_pkg::HGT_W-1:0] row0, row1, y;
	logic [lscs_pkg::WID_W-1:0] col_nxt;
	logic [lscs_pkg::HGT_W-1:0] row_nxt;

	// position of this sample, with frame start and shrunk-size wrap applied
	always_comb begin
		col0 = frame_start ? '0 : col_q;
		row0 = frame_start ? '0 : lscs_pkg::HGT_W'(row_q);
		x    = col0;
		row1 = row0;
		if (lscs_pkg::WID_W'(col0) >= width_eff) begin
			x    = '0;
			row1 = row0 + 1'b1;
		end
		y = (row1 >= height_eff) ? '0 : row1;
		col_nxt = lscs_pkg::WID_W'(x) + 1'b1;
		row_nxt = y;
		if (col_nxt >= width_eff) begin
			col_nxt = '0;
			row_nxt = y + 1'b1;
			if (row_nxt >= height_eff)
				row_nxt = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			interior_q  <= 1'b0;
			frame_end_q <= 1'b0;
			for (int i = 0; i < 6; i++)
				win_q[i] <= '0;
		end else begin
			if (accept) begin
				col_q       <= col_nxt[lscs_pkg::COL_W-1:0];
				row_q       <= row_nxt[lscs_pkg::ROW_W-1:0];
				interior_q  <= (x >= lscs_pkg::COL_W'(2)) && (y >= lscs_pkg::HGT_W'(2));
				frame_end_q <= (lscs_pkg::WID_W'(x) == width_eff - 1'b1) &&
				               (y == height_eff - 1'b1);
			end
			if (capture) begin
				win_q[0] <= win_q[3];
				win_q[1] <= win_q[4];
				win_q[2] <= win_q[5];
				win_q[3] <= up_q;
				win_q[4] <= mid_q;
				win_q[5] <= s_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q   <= x;
			s_q   <= sample;
			up_q  <= mem_up[x];
			mid_q <= mem_mid[x];
		end
		if (capture) begin
			mem_up[x_q]  <= mid_q;
			mem_mid[x_q] <= s_q;
		end
	end

	assign stencil.tl = win_q[0];
	assign stencil.t  = win_q[3];
	assign stencil.tr = up_q;
	assign stencil.l  = win_q[1];
	assign stencil.c  = win_q[4];
	assign stencil.r  = mid_q;
	assign stencil.bl = win_q[2];
	assign stencil.b  = win_q[5];
	assign stencil.br = s_q;
	assign interior   = interior_q;
	assign frame_end  = frame_end_q;

endmodule

// ----- rtl/lscs_datapath.sv -----
// ----------------------------------------------------------------------------
// lscs_datapath
// Derivatives, shift-add multiplier, restoring divider and square root.
// ----------------------------------------------------------------------------
module lscs_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lscs_pkg::cmd_t       cmd,
	input  lscs_pkg::stencil_t   stencil,
	output logic                 g_zero,
	output logic signed [31:0]   curvature,
	output logic                 saturated
);

	localparam int MW = lscs_pkg::MAG_W;

	logic signed [MW:0] dx, dy, dxx, dyy, dxy;

	function automatic logic [lscs_pkg::MAG_W-1:0] mag_of(input logic signed [MW:0] v);
		logic [MW:0] t;
		t = v[MW] ? -v : v;
		return t[MW-1:0];
	endfunction

	always_comb begin
		dx  = (MW+1)'(stencil.r) - (MW+1)'(stencil.l);
		dy  = (MW+1)'(stencil.b) - (MW+1)'(stencil.t);
		dxx = (MW+1)'(stencil.l) - ((MW+1)'(stencil.c) <<< 1) + (MW+1)'(stencil.r);
		dyy = (MW+1)'(stencil.t) - ((MW+1)'(stencil.c) <<< 1) + (MW+1)'(stencil.b);
		dxy = (MW+1)'(stencil.tl) + (MW+1)'(stencil.br)
		    - (MW+1)'(stencil.tr) - (MW+1)'(stencil.bl);
	end

	assign g_zero = (dx == '0) && (dy == '0);

	logic [MW-1:0] mdx_q, mdy_q, mdxx_q, mdyy_q, mdxy_q;
	logic sdxx_q, sdyy_q, st2_q, g_zero_q;
	logic [lscs_pkg::SQ_W-1:0]   dy2_q, dx2_q, p_q;
	logic [lscs_pkg::G_W-1:0]    g_q;
	logic signed [lscs_pkg::N_W-1:0] n_q;
	logic [lscs_pkg::PROD_W-1:0] n2_q;
	logic [lscs_pkg::G2_W-1:0]   g2_q;
	logic [lscs_pkg::G3_W-1:0]   g3_q;

	logic [lscs_pkg::PROD_W-1:0]   ma_q, mp_q;
	logic [lscs_pkg::NMAG_W-1:0]   mb_q;

	logic [lscs_pkg::DVD_W-1:0]    dvd_q;
	logic [lscs_pkg::G3_W-1:0]     drem_q;
	logic [lscs_pkg::QUO_W-1:0]    quo_q;
	logic                          ovf_q;

	logic [lscs_pkg::QUO_W-1:0]    srad_q;
	logic [lscs_pkg::ROOT_W-1:0]   root_q;
	logic [lscs_pkg::ROOT_W+1:0]   srem_q;

	logic [lscs_pkg::N_W-1:0]      nabs;
	logic signed [lscs_pkg::N_W-1:0] term_t13, term_t2;
	logic [lscs_pkg::G3_W:0]       rsh, rdiff;
	logic [lscs_pkg::ROOT_W+1:0]   r4, trial;

	always_comb begin
		nabs     = n_q[lscs_pkg::N_W-1] ? -n_q : n_q;
		term_t13 = $signed({3'b000, mp_q[49:0], 1'b0});
		term_t2  = $signed({3'b000, mp_q[50:0]});
		rsh      = {drem_q, dvd_q[lscs_pkg::DVD_W-1]};
		rdiff    = rsh - {1'b0, g3_q};
		r4       = {srem_q[lscs_pkg::ROOT_W-1:0], srad_q[lscs_pkg::QUO_W-1 -: 2]};
		trial    = {root_q, 2'b01};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			g_zero_q <= 1'b0;
		end else if (cmd.capture) begin
			g_zero_q <= g_zero;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mdx_q  <= mag_of(dx);
			mdy_q  <= mag_of(dy);
			mdxx_q <= mag_of(dxx);
			mdyy_q <= mag_of(dyy);
			mdxy_q <= mag_of(dxy);
			sdxx_q <= dxx[MW];
			sdyy_q <= dyy[MW];
			st2_q  <= dx[MW] ^ dy[MW] ^ dxy[MW];
			n_q    <= '0;
		end

		if (cmd.mul_load) begin
			mp_q <= '0;
			case (cmd.op)
				lscs_pkg::OP_DY2: begin
					ma_q <= lscs_pkg::PROD_W'(mdy_q);
					mb_q <= lscs_pkg::NMAG_W'(mdy_q);
				end
				lscs_pkg::OP_DX2: begin
					ma_q <= lscs_pkg::PROD_W'(mdx_q);
					mb_q <= lscs_pkg::NMAG_W'(mdx_q);
				end
				lscs_pkg::OP_T1: begin
					ma_q <= lscs_pkg::PROD_W'(dy2_q);
					mb_q <= lscs_pkg::NMAG_W'(mdxx_q);
				end
				lscs_pkg::OP_T3: begin
					ma_q <= lscs_pkg::PROD_W'(dx2_q);
					mb_q <= lscs_pkg::NMAG_W'(mdyy_q);
				end
				lscs_pkg::OP_P: begin
					ma_q <= lscs_pkg::PROD_W'(mdx_q);
					mb_q <= lscs_pkg::NMAG_W'(mdy_q);
				end
				lscs_pkg::OP_T2: begin
					ma_q <= lscs_pkg::PROD_W'(p_q);
					mb_q <= lscs_pkg::NMAG_W'(mdxy_q);
				end
				lscs_pkg::OP_N2: begin
					ma_q <= lscs_pkg::PROD_W'(nabs);
					mb_q <= nabs[lscs_pkg::NMAG_W-1:0];
				end
				lscs_pkg::OP_G2: begin
					ma_q <= lscs_pkg::PROD_W'(g_q);
					mb_q <= lscs_pkg::NMAG_W'(g_q);
				end
				default: begin
					ma_q <= lscs_pkg::PROD_W'(g2_q);
					mb_q <= lscs_pkg::NMAG_W'(g_q);
				end
			endcase
		end else if (cmd.mul_step) begin
			if (mb_q[0])
				mp_q <= mp_q + ma_q;
			ma_q <= ma_q << 1;
			mb_q <= mb_q >> 1;
		end

		if (cmd.mul_store) begin
			case (cmd.op)
				lscs_pkg::OP_DY2: dy2_q <= mp_q[lscs_pkg::SQ_W-1:0];
				lscs_pkg::OP_DX2: begin
					dx2_q <= mp_q[lscs_pkg::SQ_W-1:0];
					g_q   <= lscs_pkg::G_W'(mp_q[lscs_pkg::SQ_W-1:0]) + lscs_pkg::G_W'(dy2_q);
				end
				lscs_pkg::OP_T1: n_q <= sdxx_q ? n_q - term_t13 : n_q + term_t13;
				lscs_pkg::OP_T3: n_q <= sdyy_q ? n_q - term_t13 : n_q + term_t13;
				lscs_pkg::OP_P:  p_q <= mp_q[lscs_pkg::SQ_W-1:0];
				// middle term enters with its sign flipped
				lscs_pkg::OP_T2: n_q <= st2_q ? n_q + term_t2 : n_q - term_t2;
				lscs_pkg::OP_N2: n2_q <= mp_q;
				lscs_pkg::OP_G2: g2_q <= mp_q[lscs_pkg::G2_W-1:0];
				default:         g3_q <= mp_q[lscs_pkg::G3_W-1:0];
			endcase
		end

		// restoring division of |N|^2 * 2^32 by G^3
		if (cmd.div_load) begin
			dvd_q  <= {n2_q, {lscs_pkg::FRAC_W{1'b0}}};
			drem_q <= '0;
			quo_q  <= '0;
			ovf_q  <= 1'b0;
		end else if (cmd.div_step) begin
			dvd_q <= dvd_q << 1;
			ovf_q <= ovf_q | quo_q[lscs_pkg::QUO_W-1];
			if (rsh >= {1'b0, g3_q}) begin
				drem_q <= rdiff[lscs_pkg::G3_W-1:0];
				quo_q  <= {quo_q[lscs_pkg::QUO_W-2:0], 1'b1};
			end else begin
				drem_q <= rsh[lscs_pkg::G3_W-1:0];
				quo_q  <= {quo_q[lscs_pkg::QUO_W-2:0], 1'b0};
			end
		end

		// integer square root, two radicand bits per step
		if (cmd.sqrt_load) begin
			srad_q <= quo_q;
			root_q <= '0;
			srem_q <= '0;
		end else if (cmd.sqrt_step) begin
			srad_q <= srad_q << 2;
			if (r4 >= trial) begin
				srem_q <= r4 - trial;
				root_q <= {root_q[lscs_pkg::ROOT_W-2:0], 1'b1};
			end else begin
				srem_q <= r4;
				root_q <= {root_q[lscs_pkg::ROOT_W-2:0], 1'b0};
			end
		end
	end

	logic neg;
	assign neg = n_q[lscs_pkg::N_W-1];

	always_comb begin
		curvature = '0;
		saturated = 1'b0;
		if (!g_zero_q) begin
			if (!neg) begin
				saturated = ovf_q | root_q[lscs_pkg::ROOT_W-1];
				curvature = saturated ? 32'sh7FFFFFFF : $signed(root_q);
			end else begin
				saturated = ovf_q | (root_q > 32'h80000000);
				curvature = saturated ? 32'sh80000000 : $signed(~root_q + 1'b1);
			end
		end
	end

endmodule

// ----- rtl/lscs_ctrl.sv -----
// ----------------------------------------------------------------------------
// lscs_ctrl
// Sequencer: window update, nine products, division, square root, result.
// ----------------------------------------------------------------------------
`include "level_set_curvature_stencil_unit_macros.svh"

module lscs_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  lscs_pkg::stat_t stat,
	output lscs_pkg::cmd_t  cmd
);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_READ = 6'b000010,
		ST_MUL  = 6'b000100,
		ST_DIV  = 6'b001000,
		ST_SQRT = 6'b010000,
		ST_EMIT = 6'b100000
	} state_t;

	state_t state_q;
	logic [lscs_pkg::CNT_W-1:0] cnt_q;
	lscs_pkg::mul_op_t op_q;
	logic accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd           = '0;
		cmd.op        = op_q;
		cmd.capture   = (state_q == ST_READ);
		cmd.mul_load  = (state_q == ST_MUL) && (cnt_q == '0);
		cmd.mul_step  = (state_q == ST_MUL) && (cnt_q != '0) &&
		                (cnt_q <= lscs_pkg::CNT_W'(lscs_pkg::MUL_CYCLES));
		cmd.mul_store = (state_q == ST_MUL) &&
		                (cnt_q == lscs_pkg::CNT_W'(lscs_pkg::MUL_CYCLES + 1));
		cmd.div_load  = (state_q == ST_DIV) && (cnt_q == '0);
		cmd.div_step  = (state_q == ST_DIV) && (cnt_q != '0);
		cmd.sqrt_load = (state_q == ST_SQRT) && (cnt_q == '0);
		cmd.sqrt_step = (state_q == ST_SQRT) && (cnt_q != '0);
		cmd.emit      = (state_q == ST_EMIT) && stat.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			op_q    <= lscs_pkg::OP_DY2;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept)
						state_q <= ST_READ;
				end
				ST_READ: begin
					cnt_q <= '0;
					op_q  <= lscs_pkg::OP_DY2;
					if (!stat.interior)
						state_q <= ST_IDLE;
					else if (stat.g_zero)
						state_q <= ST_EMIT;
					else
						state_q <= ST_MUL;
				end
				ST_MUL: begin
					if (cmd.mul_store) begin
						cnt_q <= '0;
						if (op_q == lscs_pkg::OP_G3)
							state_q <= ST_DIV;
						else
							op_q <= lscs_pkg::mul_op_t'(op_q + 1'b1);
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DIV: begin
					if (cnt_q == lscs_pkg::CNT_W'(lscs_pkg::DIV_CYCLES)) begin
						cnt_q   <= '0;
						state_q <= ST_SQRT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_SQRT: begin
					if (cnt_q == lscs_pkg::CNT_W'(lscs_pkg::SQRT_CYCLES)) begin
						cnt_q   <= '0;
						state_q <= ST_EMIT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_EMIT: begin
					if (stat.out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`LSCS_ASSERT_NEXT(a_accept_reads, clk, arst_n, accept, state_q == ST_READ)
	`LSCS_ASSERT_IMPL(a_emit_free, clk, arst_n, cmd.emit, stat.out_free)
	`LSCS_ASSERT_IMPL(a_mul_cnt, clk, arst_n, state_q == ST_MUL,
		cnt_q <= lscs_pkg::CNT_W'(lscs_pkg::MUL_CYCLES + 1))

endmodule

// ----- rtl/level_set_curvature_stencil_unit.sv -----
// ----------------------------------------------------------------------------
// level_set_curvature_stencil_unit
// Level-set mean curvature over a raster pixel stream, 3x3 central differences.
// ----------------------------------------------------------------------------
// Samples enter one per transaction in raster order; each interior pixel's
// curvature (Q15.16, truncated toward zero, saturated) leaves when its
// lower-right neighbour has been taken. No new sample is taken while the
// previous one is still being worked on. An interior sample's time is set by
// the single shift-add multiplier that forms the nine products one after the
// other, then by the bit-serial divider (138 steps) and square root (32 steps).
// A zero-gradient pixel skips the products, the division and the square root.
// The line buffers hold whatever was written; no clearing pass runs after reset.
// ----------------------------------------------------------------------------
module level_set_curvature_stencil_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] sample_value
	input  logic        s_tuser,   // [0] frame_start
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] curvature
	output logic        m_tuser,   // [0] saturated
	output logic        m_tlast,   // frame_end
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [lscs_pkg::WID_W-1:0] width_q, width_eff;
	logic [lscs_pkg::HGT_W-1:0] height_q, height_eff;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= lscs_pkg::WID_W'(256);
			height_q <= lscs_pkg::HGT_W'(256);
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[2])
				lscs_pkg::REG_WIDTH:  width_q  <= pwdata[lscs_pkg::WID_W-1:0];
				lscs_pkg::REG_HEIGHT: height_q <= pwdata[lscs_pkg::HGT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			lscs_pkg::REG_WIDTH:  prdata = 32'(width_q);
			lscs_pkg::REG_HEIGHT: prdata = 32'(height_q);
			default:              prdata = '0;
		endcase
	end

	always_comb begin
		width_eff = width_q;
		if (width_q < lscs_pkg::WID_W'(3))
			width_eff = lscs_pkg::WID_W'(3);
		else if (width_q > lscs_pkg::WID_W'(lscs_pkg::MAX_WIDTH))
			width_eff = lscs_pkg::WID_W'(lscs_pkg::MAX_WIDTH);
		height_eff = height_q;
		if (height_q < lscs_pkg::HGT_W'(3))
			height_eff = lscs_pkg::HGT_W'(3);
		else if (height_q > lscs_pkg::HGT_W'(lscs_pkg::MAX_HGT))
			height_eff = lscs_pkg::HGT_W'(lscs_pkg::MAX_HGT);
	end

	lscs_pkg::cmd_t     cmd;
	lscs_pkg::stat_t    stat;
	lscs_pkg::stencil_t stencil;
	logic interior, frame_end, g_zero, saturated;
	logic signed [31:0] curvature;
	logic m_valid_q;

	lscs_window u_window (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (s_tvalid && s_tready),
		.sample      ($signed(s_tdata)),
		.frame_start (s_tuser),
		.width_eff   (width_eff),
		.height_eff  (height_eff),
		.capture     (cmd.capture),
		.stencil     (stencil),
		.interior    (interior),
		.frame_end   (frame_end)
	);

	lscs_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stencil   (stencil),
		.g_zero    (g_zero),
		.curvature (curvature),
		.saturated (saturated)
	);

	assign stat.interior = interior;
	assign stat.g_zero   = g_zero;
	assign stat.out_free = !m_valid_q || m_tready;

	lscs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// output register parts the result from the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			m_tdata <= curvature;
			m_tuser <= saturated;
			m_tlast <= frame_end;
		end
	end

	assign m_tvalid = m_valid_q;

endmodule

// ----- tb/level_set_curvature_stencil_unit_checker.sv -----
// ----------------------------------------------------------------------------
// Curvature stencil checker
// Watches the pixel, result and register ports of the curvature unit. It keeps
// its own line buffers, window and counters, works out the exact curvature of
// every interior pixel, and compares each result transaction in order.
// ----------------------------------------------------------------------------
module level_set_curvature_stencil_unit_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] sample_value
	input  logic        s_tuser,   // [0] frame_start
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,   // [31:0] curvature
	input  logic        m_tuser,   // [0] saturated
	input  logic        m_tlast,   // frame_end
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          errors,
	output int          pending,
	output int          results
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [31:0] curvature;
		logic        saturated;
		logic        frame_end;
	} kappa_t;

	kappa_t kappa_q[$];

	logic signed [lscs_pkg::SAMPLE_W-1:0] line_upper [lscs_pkg::MAX_WIDTH];
	logic signed [lscs_pkg::SAMPLE_W-1:0] line_middle [lscs_pkg::MAX_WIDTH];
	logic signed [lscs_pkg::SAMPLE_W-1:0] win [6];
	int unsigned col, row;
	logic [lscs_pkg::WID_W-1:0] width_reg;
	logic [lscs_pkg::HGT_W-1:0] height_reg;

	// exact |N|*2^16 / G^1.5, found as the largest q with q^2*G^3 <= (|N|*2^16)^2
	function automatic kappa_t curvature(input longint tl, t, tr, l, c, r, bl, b, br);
		longint dx, dy, dxx, dyy, dxy, g, n;
		logic [63:0] nmag, lo, hi, mid;
		logic [255:0] num2, g3, lhs;
		logic neg;
		kappa_t k;
		dx = r - l;
		dy = b - t;
		dxx = l - 2 * c + r;
		dyy = t - 2 * c + b;
		dxy = tl + br - tr - bl;
		g = dx * dx + dy * dy;
		n = 2 * dxx * dy * dy - dx * dy * dxy + 2 * dyy * dx * dx;
		k = '0;
		if (g == 0)
			return k;
		neg = n < 0;
		nmag = neg ? -n : n;
		num2 = 256'(nmag) << 16;
		num2 = num2 * num2;
		g3 = 256'(g) * 256'(g) * 256'(g);
		lo = 0;
		hi = 64'h8000_0001;
		while (lo < hi) begin
			mid = lo + (hi - lo + 1) / 2;
			lhs = 256'(mid * mid) * g3;
			if (lhs <= num2)
				lo = mid;
			else
				hi = mid - 1;
		end
		if (!neg) begin
			if (lo > 64'h7FFF_FFFF) begin
				lo = 64'h7FFF_FFFF;
				k.saturated = 1'b1;
			end
			k.curvature = lo[31:0];
		end else begin
			if (lo > 64'h8000_0000) begin
				lo = 64'h8000_0000;
				k.saturated = 1'b1;
			end
			k.curvature = 32'(-lo);
		end
		return k;
	endfunction

	task automatic take_pixel(input logic signed [lscs_pkg::SAMPLE_W-1:0] s, input logic fs);
		int unsigned w, h, x, y;
		logic signed [lscs_pkg::SAMPLE_W-1:0] up, md;
		kappa_t k;
		w = width_reg < 3 ? 3 :
			(width_reg > lscs_pkg::MAX_WIDTH ? lscs_pkg::MAX_WIDTH : width_reg);
		h = height_reg < 3 ? 3 :
			(height_reg > lscs_pkg::MAX_HGT ? lscs_pkg::MAX_HGT : height_reg);
		if (fs) begin
			col = 0;
			row = 0;
		end
		// a shrunk size ends the row, and maybe the frame, before this pixel
		if (col >= w) begin
			col = 0;
			row++;
		end
		if (row >= h)
			row = 0;
		x = col;
		y = row;
		up = line_upper[x];
		md = line_middle[x];
		if (x >= 2 && y >= 2) begin
			k = curvature(win[0], win[3], up, win[1], win[4], md, win[2], win[5], s);
			k.frame_end = (x == w - 1 && y == h - 1);
			kappa_q.push_back(k);
		end
		win[0] = win[3];
		win[1] = win[4];
		win[2] = win[5];
		win[3] = up;
		win[4] = md;
		win[5] = s;
		line_upper[x] = md;
		line_middle[x] = s;
		col = x + 1;
		if (col >= w) begin
			col = 0;
			row = y + 1;
			if (row >= h)
				row = 0;
		end
	endtask

	assign pending = kappa_q.size();

	always @(posedge clk or negedge arst_n) begin
		kappa_t want;
		if (!arst_n) begin
			kappa_q.delete();
			for (int i = 0; i < lscs_pkg::MAX_WIDTH; i++) begin
				line_upper[i] = '0;
				line_middle[i] = '0;
			end
			for (int i = 0; i < 6; i++)
				win[i] = '0;
			col = 0;
			row = 0;
			width_reg = 256;
			height_reg = 256;
			errors = 0;
			results = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == lscs_pkg::REG_WIDTH)
					width_reg = pwdata[lscs_pkg::WID_W-1:0];
				else
					height_reg = pwdata[lscs_pkg::HGT_W-1:0];
			end
			if (m_tvalid && m_tready) begin
				results++;
				if (kappa_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected result transaction, actual %h/%b/%b",
						$time, m_tdata, m_tuser, m_tlast);
				end else begin
					want = kappa_q.pop_front();
					if (m_tdata !== want.curvature) begin
						errors++;
						$display("%0t: curvature expected %h actual %h",
							$time, want.curvature, m_tdata);
					end
					if (m_tuser !== want.saturated) begin
						errors++;
						$display("%0t: saturated expected %b actual %b",
							$time, want.saturated, m_tuser);
					end
					if (m_tlast !== want.frame_end) begin
						errors++;
						$display("%0t: frame_end expected %b actual %b",
							$time, want.frame_end, m_tlast);
					end
				end
			end
			if (s_tvalid && s_tready)
				take_pixel(s_tdata, s_tuser);
		end
	end

endmodule

// ----- tb/tb_level_set_curvature_stencil_unit.sv -----
// ----------------------------------------------------------------------------
// Curvature stencil unit testbench
// Drives pixel frames of many sizes, register changes and random back-pressure
// into the unit; a checker beside it predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_level_set_curvature_stencil_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] ADDR_WIDTH  = {lscs_pkg::REG_WIDTH, 2'b00};
	localparam logic [2:0] ADDR_HEIGHT = {lscs_pkg::REG_HEIGHT, 2'b00};
	localparam int SETTLE = 800;     // longer than one interior pixel
	localparam int RANDOM_PIXELS = 1100;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;       // [15:0] sample_value
	logic        s_tuser = 1'b0;     // [0] frame_start
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;            // [31:0] curvature
	logic        m_tuser;            // [0] saturated
	logic        m_tlast;            // frame_end
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	int errors, pending, results;
	int pixels_sent;
	bit burst_mode;   // no gaps on the pixel side while set

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	level_set_curvature_stencil_unit u_dut (.*);

	level_set_curvature_stencil_unit_checker u_chk (.*);

	initial begin
		#50_000_000;
		$display("Mismatches found");
		$finish;
	end

	task automatic reg_write(input logic [2:0] addr, input logic [31:0] value);
		@(negedge clk);
		psel = 1'b1;
		pwrite = 1'b1;
		paddr = addr;
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// called at a falling edge
	task automatic send_pixel(input logic [15:0] value, input logic fs);
		int gap;
		s_tdata = value;
		s_tuser = fs;
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		pixels_sent++;
		@(negedge clk);
		gap = burst_mode ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic wait_idle();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic set_size(input int w, input int h);
		wait_idle();
		reg_write(ADDR_WIDTH, w);
		reg_write(ADDR_HEIGHT, h);
		@(negedge clk);
	endtask

	// 3x3 frame, one result: rows top, middle, bottom
	task automatic send_tile(input logic [15:0] p [9]);
		for (int i = 0; i < 9; i++)
			send_pixel(p[i], i == 0);
	endtask

	// smooth surfaces with noise, or fully random content; may stop early
	task automatic send_frame(input int w, input int h, input bit fs, input int stop_at);
		int ax, ay, q, base, nz, v;
		bit wild;
		wild = $urandom_range(0, 3) == 0;
		ax = $urandom_range(0, 400) - 200;
		ay = $urandom_range(0, 400) - 200;
		q = $urandom_range(0, 60) - 30;
		base = $urandom_range(0, 20000) - 10000;
		nz = $urandom_range(0, 8);
		for (int y = 0; y < h; y++)
			for (int x = 0; x < w; x++) begin
				if (y * w + x >= stop_at)
					return;
				if (wild)
					v = $urandom;
				else
					v = base + x * ax + y * ay + (x * x + y * y) * q
						+ $urandom_range(0, 2 * nz) - nz;
				send_pixel(v[15:0], fs && x == 0 && y == 0);
			end
	endtask

	// receiver: random stalls, runs without stalls, and one long hold-off
	initial begin
		int gap, taken;
		bit smooth;
		taken = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			m_tready = 1'b1;
			do @(posedge clk); while (!m_tvalid);
			taken++;
			if (taken % 40 == 0)
				smooth = $urandom_range(0, 1);
			gap = smooth ? 0 : $urandom_range(0, 9);
			if (taken == 60)
				gap = 3000;
			if (gap > 0) begin
				@(negedge clk);
				m_tready = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
	end

	initial begin
		logic [15:0] tile [9];
		int w, h, frames, stop_at;
		pixels_sent = 0;
		burst_mode = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// zero gradient, then positive and negative overflow
		set_size(3, 3);
		tile = '{16'h1234, 16'h1234, 16'h1234, 16'h1234, 16'h1234,
			16'h1234, 16'h1234, 16'h1234, 16'h1234};
		send_tile(tile);
		tile = '{16'h0000, 16'h7FFF, 16'h0000, 16'h0000, 16'h8000,
			16'h0001, 16'h0000, 16'h7FFF, 16'h0000};
		send_tile(tile);
		tile = '{16'hFFFF, 16'h8000, 16'h7FFF, 16'h0000, 16'h7FFF,
			16'h0001, 16'h8000, 16'h8000, 16'h7FFF};
		send_tile(tile);

		// shrink width, then height, in mid-frame
		set_size(8, 6);
		send_frame(8, 6, 1'b1, 8 * 3 + 6);
		wait_idle();
		reg_write(ADDR_WIDTH, 5);
		send_frame(5, 6, 1'b0, 12);
		wait_idle();
		reg_write(ADDR_HEIGHT, 3);
		send_frame(5, 3, 1'b0, 15);

		// widest rows and tallest frame, start of the first row only
		set_size(lscs_pkg::MAX_WIDTH, lscs_pkg::MAX_HGT);
		send_frame(lscs_pkg::MAX_WIDTH, 3, 1'b1, 64);

		while (pixels_sent < RANDOM_PIXELS) begin
			w = $urandom_range(0, 5) == 0 ? 3 : $urandom_range(3, 9);
			h = $urandom_range(0, 5) == 0 ? 3 : $urandom_range(3, 7);
			set_size(w, h);
			frames = $urandom_range(1, 3);
			for (int f = 0; f < frames; f++) begin
				burst_mode = $urandom_range(0, 2) == 0;
				// mostly whole frames; sometimes cut short or wrapped without a marker
				stop_at = $urandom_range(0, 7) == 0 ? $urandom_range(1, w * h - 1) : w * h;
				send_frame(w, h, f == 0 || $urandom_range(0, 3) != 0, stop_at);
			end
			burst_mode = 1'b0;
		end

		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
		$display("Sent %0d pixels over many frame sizes and register settings;", pixels_sent);
		$display("checked %0d curvature results, %0d errors.", results, errors);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
